>>> rtl/core/line_splitter_sanitiser_top_assert.svh
// assertion macros shared by the rtl files
// each macro expects clk and rst in the scope where it is used
`ifndef LINE_SPLITTER_SANITISER_TOP_ASSERT_SVH
`define LINE_SPLITTER_SANITISER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LSS_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lss check failed");

// next-cycle implication
`define LSS_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lss check failed");

`else

`define LSS_CHECK(label, ante, cons)
`define LSS_CHECK_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/lss_pkg.sv
`timescale 1ns / 1ps

package lss_pkg;

  localparam int BYTE_W            = 8;
  localparam int LINE_CAPACITY_DEF = 64;

  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'h20;

endpackage

>>> rtl/core/lss_front.sv
`timescale 1ns / 1ps

module lss_front #(
  parameter int LINE_CAPACITY = lss_pkg::LINE_CAPACITY_DEF,
  parameter int IDX_W         = $clog2(LINE_CAPACITY),
  parameter int CNT_W         = $clog2(LINE_CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rx_valid,
  input  logic                       rx_stall,
  input  logic [lss_pkg::BYTE_W-1:0] rx_byte,
  output logic                       wr_en,
  output logic [IDX_W:0]             wr_addr,
  output logic [lss_pkg::BYTE_W-1:0] wr_data,
  output logic                       push,
  output logic [CNT_W-1:0]           push_len
);
  import lss_pkg::*;

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] trim;
  logic [CNT_W-1:0] trim_next;
  logic             wr_bank;
  logic             accept;
  logic             full;
  logic [IDX_W-1:0] base;
  logic [CNT_W-1:0] base_inc;
  logic             is_nl;

  assign accept   = rx_valid && !rx_stall;
  assign full     = (fill == CNT_W'(LINE_CAPACITY));
  // a full store is dropped and the byte becomes the first entry
  assign base     = full ? '0 : fill[IDX_W-1:0];
  assign base_inc = CNT_W'(base) + CNT_W'(1);
  assign is_nl    = (rx_byte == NEWLINE_CODE);

  assign wr_en    = accept;
  assign wr_addr  = {wr_bank, base};
  assign wr_data  = rx_byte;
  assign push     = accept && is_nl;
  assign push_len = full ? '0 : trim;

  always_comb begin
    fill_next = fill;
    trim_next = trim;
    if (accept) begin
      if (is_nl) begin
        fill_next = '0;
        trim_next = '0;
      end else begin
        fill_next = base_inc;
        // trim tracks the end of the last byte above space
        if (rx_byte > SPACE_CODE) begin
          trim_next = base_inc;
        end else if (full) begin
          trim_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      trim    <= '0;
      wr_bank <= 1'b0;
    end else begin
      fill <= fill_next;
      trim <= trim_next;
      if (push) begin
        wr_bank <= ~wr_bank;
      end
    end
  end

endmodule

>>> rtl/core/lss_job_fifo.sv
`timescale 1ns / 1ps
`include "line_splitter_sanitiser_top_assert.svh"

module lss_job_fifo #(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         not_empty,
  output logic         full
);

  logic [W-1:0] entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign head      = entry[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `LSS_CHECK(a_no_push_full, push, !full)
  `LSS_CHECK(a_no_pop_empty, pop, not_empty)
  `LSS_CHECK(a_count_range, 1'b1, count != 2'd3)

endmodule

>>> rtl/core/lss_back.sv
`timescale 1ns / 1ps
`include "line_splitter_sanitiser_top_assert.svh"

module lss_back #(
  parameter int LINE_CAPACITY = lss_pkg::LINE_CAPACITY_DEF,
  parameter int IDX_W         = $clog2(LINE_CAPACITY),
  parameter int CNT_W         = $clog2(LINE_CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [IDX_W:0]             wr_addr,
  input  logic [lss_pkg::BYTE_W-1:0] wr_data,
  input  logic                       job_valid,
  input  logic [CNT_W-1:0]           job_len,
  output logic                       pop,
  output logic                       line_valid,
  input  logic                       line_stall,
  output logic [lss_pkg::BYTE_W-1:0] line_char,
  output logic                       last_of_line,
  output logic                       empty_line
);
  import lss_pkg::*;

  localparam int DEPTH = 2 * (1 << IDX_W);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_FETCH = 4'b0010,
    B_LOAD  = 4'b0100,
    B_HOLD  = 4'b1000
  } back_state_t;

  back_state_t          state;
  logic [BYTE_W-1:0]    mem [DEPTH];
  logic [BYTE_W-1:0]    rd_data;
  logic [BYTE_W-1:0]    clean;
  logic                 rd_en;
  logic                 rd_bank;
  logic [IDX_W-1:0]     k;
  logic [CNT_W-1:0]     cur_len;

  // two banks: the front fills one while this side reads the other
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_en = (state == B_FETCH);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[{rd_bank, k}];
    end
  end

  assign clean = (rd_data < SPACE_CODE) ? SPACE_CODE : rd_data;
  assign pop   = (state == B_HOLD) && !line_stall && last_of_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      line_valid <= 1'b0;
      rd_bank    <= 1'b0;
      k          <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            k       <= '0;
            cur_len <= job_len;
            if (job_len == '0) begin
              line_char    <= '0;
              last_of_line <= 1'b1;
              empty_line   <= 1'b1;
              line_valid   <= 1'b1;
              state        <= B_HOLD;
            end else begin
              state <= B_FETCH;
            end
          end
        end
        B_FETCH: begin
          state <= B_LOAD;
        end
        B_LOAD: begin
          line_char    <= clean;
          last_of_line <= (CNT_W'(k) + CNT_W'(1) == cur_len);
          empty_line   <= 1'b0;
          line_valid   <= 1'b1;
          state        <= B_HOLD;
        end
        B_HOLD: begin
          if (!line_stall) begin
            line_valid <= 1'b0;
            if (last_of_line) begin
              rd_bank <= ~rd_bank;
              state   <= B_IDLE;
            end else begin
              k     <= k + IDX_W'(1);
              state <= B_FETCH;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `LSS_CHECK(a_hold_valid, state == B_HOLD, line_valid)
  `LSS_CHECK(a_job_kept, state != B_IDLE, job_valid)
  `LSS_CHECK(a_empty_is_last, line_valid && empty_line, last_of_line)
  `LSS_CHECK_NEXT(a_fetch_in_range, state == B_FETCH, CNT_W'(k) < cur_len)

endmodule

>>> rtl/core/line_splitter_sanitiser_top.sv
`timescale 1ns / 1ps
// channel | handshake             | payload
// rx      | rx_valid / rx_stall   | rx_byte
// line    | line_valid / line_stall | line_char, last_of_line, empty_line
//
// a byte is taken while rx_stall is low; the front stalls only while two lines wait to be sent
// each line is set up from the idle state, then each character passes through the fetch, load and hold states
//   (registered read of the line store, load into the output register, handshake)
// an empty line goes from the idle state straight to hold for its single request
// synchronous reset clears the counters, queue and state; the store needs no clearing
// the front keeps taking bytes into the other bank during line_stall unless the queue is full

module line_splitter_sanitiser_top #(
  parameter int LINE_CAPACITY = lss_pkg::LINE_CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rx_valid,
  output logic                       rx_stall,
  input  logic [lss_pkg::BYTE_W-1:0] rx_byte,
  output logic                       line_valid,
  input  logic                       line_stall,
  output logic [lss_pkg::BYTE_W-1:0] line_char,
  output logic                       last_of_line,
  output logic                       empty_line
);
  import lss_pkg::*;

  localparam int IDX_W = $clog2(LINE_CAPACITY);
  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

  logic              wr_en;
  logic [IDX_W:0]    wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              push;
  logic [CNT_W-1:0]  push_len;
  logic              pop;
  logic [CNT_W-1:0]  job_len;
  logic              job_valid;
  logic              job_full;

  assign rx_stall = job_full;

  lss_front #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .push     (push),
    .push_len (push_len)
  );

  lss_job_fifo #(
    .W (CNT_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_len),
    .pop       (pop),
    .head      (job_len),
    .not_empty (job_valid),
    .full      (job_full)
  );

  lss_back #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .job_valid    (job_valid),
    .job_len      (job_len),
    .pop          (pop),
    .line_valid   (line_valid),
    .line_stall   (line_stall),
    .line_char    (line_char),
    .last_of_line (last_of_line),
    .empty_line   (empty_line)
  );

endmodule
